@@ src/pfsa_pkg.sv @@
// Shared types and constants for the automaton path log-likelihood scorer.
// Used by pfsa_ctrl, pfsa_dpath and pfsa_path_log_likelihood; no dependencies.
package pfsa_pkg;

   // Fixed field widths of the request and result items.
   localparam int KIND_W   = 2;
   localparam int STATE_W  = 6;
   localparam int SYMBOL_W = 4;
   localparam int COST_W   = 24;
   localparam int OUT_W    = 24;
   localparam int SUM_W    = 48;

   // The divider produces one quotient bit per cycle over the whole sum.
   localparam int DIV_CNT_W = $clog2(SUM_W);

   // Default sizes handed to the top level.
   localparam int STATE_COUNT_DEF = 64;
   localparam int NUM_SYMBOLS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 24;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      REQ_WRITE  = 2'd0,
      REQ_START  = 2'd1,
      REQ_SYMBOL = 2'd2
   } req_kind_type;

   // One request item.
   typedef struct packed {
      logic [KIND_W-1:0]   req_type;
      logic [STATE_W-1:0]  row_state;
      logic [SYMBOL_W-1:0] row_symbol;
      logic [STATE_W-1:0]  entry_next;
      logic                entry_allowed;
      logic [COST_W-1:0]   entry_cost;
      logic [STATE_W-1:0]  start_state;
      logic [SYMBOL_W-1:0] in_symbol;
      logic                last_symbol;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [OUT_W-1:0] mean_cost;
      logic             failed;
      logic [OUT_W-1:0] seq_length;
   } rsp_item_type;

   // One word of the transition table.
   typedef struct packed {
      logic [STATE_W-1:0] next_state;
      logic               allowed;
      logic [COST_W-1:0]  cost;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic apply;
      logic div_load;
      logic div_step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic fail_next;
      logic out_free;
   } sts_type;

endpackage

@@ src/pfsa_ctrl.sv @@
// Controller state machine of the automaton scorer.
// Depends on pfsa_pkg for command, status and request kind types.
module pfsa_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [pfsa_pkg::KIND_W-1:0]  req_kind,
   output logic                         req_stall,
   input  pfsa_pkg::sts_type            sts,
   output pfsa_pkg::cmd_type            cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_APPLY    = 5'b00010,
      S_DIV_LOAD = 5'b00100,
      S_DIV      = 5'b01000,
      S_EMIT     = 5'b10000
   } state_type;

   localparam logic [pfsa_pkg::DIV_CNT_W-1:0] DIV_LAST =
      pfsa_pkg::DIV_CNT_W'(pfsa_pkg::SUM_W - 1);

   state_type                       state_ff, state_in;
   logic [pfsa_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   // Input is taken only while no item is in flight.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_kind == pfsa_pkg::REQ_SYMBOL) begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (sts.last) begin
               state_in = sts.fail_next ? S_EMIT : S_DIV_LOAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

@@ src/pfsa_dpath.sv @@
// Datapath of the automaton scorer: transition table, accumulators,
// restoring divider and result register. Depends on pfsa_pkg.
module pfsa_dpath #(
   parameter int STATE_COUNT = pfsa_pkg::STATE_COUNT_DEF,
   parameter int NUM_SYMBOLS = pfsa_pkg::NUM_SYMBOLS_DEF,
   parameter int COUNT_BITS  = pfsa_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pfsa_pkg::req_item_type  req_payload,
   input  pfsa_pkg::cmd_type       cmd,
   output pfsa_pkg::sts_type       sts,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pfsa_pkg::rsp_item_type  rsp_payload
);

   localparam int TABLE_DEPTH = STATE_COUNT * NUM_SYMBOLS;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int SUM_W       = pfsa_pkg::SUM_W;
   localparam int OUT_W       = pfsa_pkg::OUT_W;

   pfsa_pkg::entry_type table_mem [TABLE_DEPTH];
   pfsa_pkg::entry_type rd_entry_ff;
   pfsa_pkg::entry_type wr_entry;

   logic [31:0]                    wr_index, rd_index;
   logic                           wr_en, row_ok, sym_ok, cur_ok;

   logic [pfsa_pkg::STATE_W-1:0]   state_ff, state_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic                           fail_ff, fail_in;
   logic                           last_ff, last_in;
   logic                           hit_ff, hit_in;
   logic [SUM_W-1:0]               quo_ff, quo_in;
   logic [COUNT_BITS-1:0]          rem_ff, rem_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pfsa_pkg::rsp_item_type         rsp_payload_ff, rsp_payload_in;

   logic [SUM_W:0]                 sum_add;
   logic [COUNT_BITS:0]            trial, diff;
   logic                           trial_ge;
   logic [31:0]                    count_wide;
   logic                           step_ok;

   // Table addressing: a state row holds one entry per symbol.
   always_comb begin
      wr_index = 32'(req_payload.row_state) * 32'(NUM_SYMBOLS)
               + 32'(req_payload.row_symbol);
      rd_index = 32'(state_ff) * 32'(NUM_SYMBOLS) + 32'(req_payload.in_symbol);
      row_ok   = (32'(req_payload.row_state) < 32'(STATE_COUNT))
              && (32'(req_payload.row_symbol) < 32'(NUM_SYMBOLS));
      sym_ok   = (32'(req_payload.in_symbol) < 32'(NUM_SYMBOLS));
      cur_ok   = (32'(state_ff) < 32'(STATE_COUNT));
      wr_en    = cmd.take && (req_payload.req_type == pfsa_pkg::REQ_WRITE) && row_ok;
      wr_entry.next_state = req_payload.entry_next;
      wr_entry.allowed    = req_payload.entry_allowed;
      wr_entry.cost       = req_payload.entry_cost;
   end

   // Transition table with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_index[ADDR_W-1:0]] <= wr_entry;
      end
      rd_entry_ff <= table_mem[rd_index[ADDR_W-1:0]];
   end

   // Accumulator update, divider step and result formatting.
   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      fail_in        = fail_ff;
      last_in        = last_ff;
      hit_in         = hit_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      rsp_payload_in = rsp_payload_ff;

      step_ok  = hit_ff && rd_entry_ff.allowed;
      sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(rd_entry_ff.cost);
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      diff     = trial - {1'b0, count_ff};
      trial_ge = (trial >= {1'b0, count_ff});
      count_wide = 32'(count_ff);

      // Capture the request at its transfer.
      if (cmd.take) begin
         if (req_payload.req_type == pfsa_pkg::REQ_START) begin
            state_in = req_payload.start_state;
            sum_in   = '0;
            count_in = '0;
            fail_in  = 1'b0;
         end
         last_in = req_payload.last_symbol;
         hit_in  = sym_ok && cur_ok;
      end

      // Apply one symbol using the entry read in the previous cycle.
      if (cmd.apply) begin
         if (!fail_ff) begin
            if (step_ok) begin
               sum_in   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
               state_in = rd_entry_ff.next_state;
            end else begin
               fail_in = 1'b1;
            end
         end
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end

      // Restoring division, one quotient bit per cycle.
      if (cmd.div_load) begin
         quo_in = sum_ff;
         rem_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quo_in = {quo_ff[SUM_W-2:0], trial_ge};
      end

      // Load the result register and clear the accumulators.
      if (cmd.emit) begin
         if (fail_ff) begin
            rsp_payload_in.mean_cost = '0;
         end else if (|quo_ff[SUM_W-1:OUT_W]) begin
            rsp_payload_in.mean_cost = '1;
         end else begin
            rsp_payload_in.mean_cost = quo_ff[OUT_W-1:0];
         end
         rsp_payload_in.failed = fail_ff;
         if (count_wide > 32'(24'hFFFFFF)) begin
            rsp_payload_in.seq_length = '1;
         end else begin
            rsp_payload_in.seq_length = count_wide[OUT_W-1:0];
         end
         sum_in   = '0;
         count_in = '0;
         fail_in  = 1'b0;
      end

      // Result register holds until its transfer.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      sts.last      = last_ff;
      sts.fail_next = fail_ff || !step_ok;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Control and accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      last_ff        <= last_in;
      hit_ff         <= hit_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ src/pfsa_path_log_likelihood.sv @@
// Top level of the automaton path log-likelihood scorer.
// Depends on pfsa_pkg, pfsa_ctrl and pfsa_dpath.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   pfsa_pkg::req_item_type
//   rsp       out        rsp_valid/rsp_stall   pfsa_pkg::rsp_item_type
//
// Writes, starts and unknown items are only taken; a symbol is a table read then
// the accumulate, since each read address needs the next state read before.
// The last symbol then adds a load, 48 restoring divider steps and the result
// load; a failed sequence skips the divider and goes to the result load alone.
// Reset is synchronous and clears control and accumulators, not the table.
// A waiting result does not block input; only a second result stalls behind it.
module pfsa_path_log_likelihood #(
   parameter int STATE_COUNT = pfsa_pkg::STATE_COUNT_DEF,
   parameter int NUM_SYMBOLS = pfsa_pkg::NUM_SYMBOLS_DEF,
   parameter int COUNT_BITS  = pfsa_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pfsa_pkg::req_item_type  req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pfsa_pkg::rsp_item_type  rsp_payload
);

   pfsa_pkg::cmd_type cmd;
   pfsa_pkg::sts_type sts;

   // Sequencing of table reads, accumulation and division.
   pfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table, accumulators, divider and result register.
   pfsa_dpath #(
      .STATE_COUNT (STATE_COUNT),
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // At most one command is active in any cycle.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.apply, cmd.div_load, cmd.div_step, cmd.emit}))
      else $error("more than one datapath command active");

   // A new result is loaded only when the result register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over an unaccepted result");

   // A failed sequence reports a zero mean cost.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.failed) |-> (rsp_payload.mean_cost == '0))
      else $error("failed result carries a nonzero mean cost");

   // Input is held off while a symbol is being applied.
   a_apply_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> req_stall)
      else $error("input open during symbol update");

endmodule
